// ----- hdl/assert_macros.svh -----
// shared assertion macros for the deframer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked from one edge to the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bsfr_pkg.sv -----
package bsfr_pkg;

  localparam int BYTE_W          = 8;
  localparam int KIND_W          = 3;
  localparam int POS_W           = 8;
  localparam int CRC_W           = 16;
  localparam int MAX_FRAME_BYTES = 128;
  localparam int MIN_FRAME_BYTES = 4;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'h7e;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h7d;
  localparam logic [BYTE_W-1:0] ESC_XOR      = 8'h20;
  localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT     = 16'h0000;

  // result word kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DATA      = 3'd0,
    KIND_GOOD      = 3'd1,
    KIND_CRC_ERR   = 3'd2,
    KIND_SHORT     = 3'd3,
    KIND_OVERFLOW  = 3'd4,
    KIND_ESC_ABORT = 3'd5
  } kind_t;

  // configuration register indexes
  typedef enum logic {
    CFG_SYNC   = 1'b0,
    CFG_ESCAPE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_value;
    logic [BYTE_W-1:0] escape_value;
  } cfg_t;

  // registered input word handed to the deframer core
  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] rx_byte;
  } stage_t;

  // crc-16, msb first, one byte folded in over eight bit steps
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/bsfr_if.sv -----
// raw line byte channel
interface bsfr_in_if;
  logic                       valid;
  logic                       ready;
  logic [bsfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// deframed result channel
interface bsfr_out_if;
  logic                        valid;
  logic                        ready;
  logic [bsfr_pkg::KIND_W-1:0] kind;
  logic [bsfr_pkg::BYTE_W-1:0] data_byte;
  logic [bsfr_pkg::POS_W-1:0]  position;
  logic [bsfr_pkg::CRC_W-1:0]  frame_crc;

  modport source (output valid, output kind, output data_byte, output position,
                  output frame_crc, input ready);
  modport sink   (input valid, input kind, input data_byte, input position,
                  input frame_crc, output ready);
endinterface

// ----- hdl/bsfr_cfg_regs.sv -----
module bsfr_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  bsfr_pkg::cfg_reg_t          cfg_idx,
  input  logic [bsfr_pkg::BYTE_W-1:0] cfg_wdata,
  output bsfr_pkg::cfg_t              cfg
);
  import bsfr_pkg::*;

  logic [BYTE_W-1:0] sync_r, sync_nxt;
  logic [BYTE_W-1:0] escape_r, escape_nxt;

  // register write decode
  always_comb begin
    sync_nxt   = sync_r;
    escape_nxt = escape_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SYNC:   sync_nxt   = cfg_wdata;
        CFG_ESCAPE: escape_nxt = cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r   <= SYNC_RESET;
      escape_r <= ESCAPE_RESET;
    end else begin
      sync_r   <= sync_nxt;
      escape_r <= escape_nxt;
    end
  end

  assign cfg.sync_value   = sync_r;
  assign cfg.escape_value = escape_r;

endmodule

// ----- hdl/bsfr_in_stage.sv -----
module bsfr_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  bsfr_in_if.sink         in_ch,
  input  logic            adv,
  output bsfr_pkg::stage_t stage
);
  import bsfr_pkg::*;

  logic              vld_r;
  logic [BYTE_W-1:0] byte_r;

  // the stage moves on whenever the core can take its word, never in reset
  assign in_ch.ready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_ch.valid) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign stage.vld     = vld_r;
  assign stage.rx_byte = byte_r;

endmodule

// ----- hdl/bsfr_core.sv -----
`include "assert_macros.svh"

module bsfr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  bsfr_pkg::stage_t stage,
  input  bsfr_pkg::cfg_t   cfg,
  output logic             adv,
  bsfr_out_if.source       out_ch
);
  import bsfr_pkg::*;

  // frame state
  logic              in_frame_r, in_frame_nxt;
  logic              esc_r, esc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] held0_r, held0_nxt;
  logic [BYTE_W-1:0] held1_r, held1_nxt;

  // result register
  logic              out_vld_r, out_vld_nxt;
  kind_t             kind_r, kind_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CRC_W-1:0]  ocrc_r, ocrc_nxt;

  logic              res_vld;
  logic              take;
  logic [BYTE_W-1:0] b;
  logic [CRC_W-1:0]  got_crc;

  assign adv     = !out_vld_r || out_ch.ready;
  assign take    = adv && stage.vld;
  assign b       = stage.rx_byte;
  assign got_crc = {held1_r, held0_r};

  // deframing decision for the word in the input stage
  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    res_vld      = 1'b0;
    kind_nxt     = KIND_DATA;
    data_nxt     = '0;
    pos_nxt      = POS_W'(cnt_r);
    ocrc_nxt     = '0;

    if (!in_frame_r) begin
      // hunting: only sync opens a frame
      if (b == cfg.sync_value) begin
        in_frame_nxt = 1'b1;
        esc_nxt      = 1'b0;
        cnt_nxt      = '0;
        crc_nxt      = CRC_INIT;
      end
    end else if (cnt_r >= CNT_W'(MAX_FRAME_BYTES)) begin
      // frame too long, sync lost
      in_frame_nxt = 1'b0;
      esc_nxt      = 1'b0;
      res_vld      = 1'b1;
      kind_nxt     = KIND_OVERFLOW;
    end else if (esc_r && (b == cfg.sync_value)) begin
      // sync straight after escape restarts the frame
      esc_nxt  = 1'b0;
      cnt_nxt  = '0;
      crc_nxt  = CRC_INIT;
      res_vld  = 1'b1;
      kind_nxt = KIND_ESC_ABORT;
    end else if (!esc_r && (b == cfg.escape_value)) begin
      esc_nxt = 1'b1;
    end else if (!esc_r && (b == cfg.sync_value)) begin
      // closing sync
      if (cnt_r == '0) begin
        // empty frame stays open
      end else if (cnt_r < CNT_W'(MIN_FRAME_BYTES)) begin
        cnt_nxt  = '0;
        crc_nxt  = CRC_INIT;
        res_vld  = 1'b1;
        kind_nxt = KIND_SHORT;
      end else begin
        res_vld  = 1'b1;
        ocrc_nxt = crc_r;
        cnt_nxt  = '0;
        crc_nxt  = CRC_INIT;
        if (got_crc == crc_r) begin
          in_frame_nxt = 1'b0;
          kind_nxt     = KIND_GOOD;
        end else begin
          kind_nxt = KIND_CRC_ERR;
        end
      end
    end else begin
      // data word, unescaped if needed; crc trails by two words
      esc_nxt   = 1'b0;
      data_nxt  = esc_r ? (b ^ ESC_XOR) : b;
      if (cnt_r >= CNT_W'(2)) begin
        crc_nxt = crc_feed(crc_r, held0_r);
      end
      held0_nxt = held1_r;
      held1_nxt = data_nxt;
      cnt_nxt   = cnt_r + CNT_W'(1);
      res_vld   = 1'b1;
      kind_nxt  = KIND_DATA;
    end
  end

  assign out_vld_nxt = adv ? (stage.vld && res_vld) : out_vld_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      cnt_r      <= '0;
      crc_r      <= CRC_INIT;
      out_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (take) begin
        in_frame_r <= in_frame_nxt;
        esc_r      <= esc_nxt;
        cnt_r      <= cnt_nxt;
        crc_r      <= crc_nxt;
      end
    end
  end

  // held bytes and result payload
  always_ff @(posedge clk) begin
    if (take) begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
    if (take && res_vld) begin
      kind_r <= kind_nxt;
      data_r <= data_nxt;
      pos_r  <= pos_nxt;
      ocrc_r <= ocrc_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.kind      = kind_r;
  assign out_ch.data_byte = data_r;
  assign out_ch.position  = pos_r;
  assign out_ch.frame_crc = ocrc_r;

  // checks
  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(MAX_FRAME_BYTES),
    "byte count beyond frame limit")
  `ASSERT_ALWAYS(a_esc_in_frame, !esc_r || in_frame_r,
    "escape pending while hunting")
  `ASSERT_NEXT(a_good_hunts, take && res_vld && (kind_nxt == KIND_GOOD),
    !in_frame_r && (cnt_r == '0), "good frame did not return to hunting")
  `ASSERT_ALWAYS(a_data_no_crc, !(out_vld_r && (kind_r == KIND_DATA)) || (ocrc_r == '0),
    "data word carries a crc")

endmodule

// ----- hdl/byte_stuffed_frame_receiver_crc16.sv -----
// an accepted word passes through the input register and then into the result register
// throughput: one received byte per cycle while no result is left waiting, limited by the single state update
// a result left waiting holds the input register and keeps input ready low until taken
// reset: synchronous active-low rst_n; hunting for sync, registers back to 0x7e / 0x7d
module byte_stuffed_frame_receiver_crc16 (
  input  logic                        clk,
  input  logic                        rst_n,
  bsfr_in_if.sink                     in_ch,
  bsfr_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  bsfr_pkg::cfg_reg_t          cfg_idx,
  input  logic [bsfr_pkg::BYTE_W-1:0] cfg_wdata
);
  import bsfr_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   adv;

  // configuration registers
  bsfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register
  bsfr_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .stage (stage)
  );

  // deframer state and result register
  bsfr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .stage  (stage),
    .cfg    (cfg),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule

// ----- tb/byte_stuffed_frame_receiver_crc16_tb.sv -----
`timescale 1ns / 100ps

module byte_stuffed_frame_receiver_crc16_tb;
  import bsfr_pkg::*;

  typedef struct {
    kind_t              kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [POS_W-1:0]   position;
    logic [CRC_W-1:0]   frame_crc;
  } deframe_result_t;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  cfg_reg_t          cfg_idx;
  logic [BYTE_W-1:0] cfg_wdata;

  bsfr_in_if  in_ch ();
  bsfr_out_if out_ch ();

  byte_stuffed_frame_receiver_crc16 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // deframer shadow state and shadow registers
  logic [BYTE_W-1:0] sync_shadow   = SYNC_RESET;
  logic [BYTE_W-1:0] escape_shadow = ESCAPE_RESET;
  logic              shadow_in_frame = 1'b0;
  logic              shadow_esc_pending = 1'b0;
  int                shadow_count = 0;
  logic [CRC_W-1:0]  shadow_crc = '0;
  logic [BYTE_W-1:0] shadow_held [2] = '{8'h00, 8'h00};

  deframe_result_t   due_results[$];
  int                fail_count = 0;
  int                words_accepted = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                hold_cycles = 0;

  // crc-16 ccitt, msb first, zero init
  function automatic logic [CRC_W-1:0] crc16_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] acc;
    acc = crc ^ {b, 8'h00};
    repeat (8) begin
      if (acc[CRC_W-1]) begin
        acc = (acc << 1) ^ CRC_POLY;
      end else begin
        acc = acc << 1;
      end
    end
    return acc;
  endfunction

  function automatic void restart_frame();
    shadow_in_frame    = 1'b1;
    shadow_esc_pending = 1'b0;
    shadow_count       = 0;
    shadow_crc         = CRC_INIT;
  endfunction

  // advance the shadow deframer by one line byte; returns 1 when a result is due
  function automatic bit deframe_predict(input logic [BYTE_W-1:0] raw,
                                         output deframe_result_t r);
    logic [BYTE_W-1:0] b;
    logic [CRC_W-1:0]  got;
    b              = raw;
    r.kind         = KIND_DATA;
    r.data_byte    = '0;
    r.position     = POS_W'(shadow_count);
    r.frame_crc    = '0;
    // hunting for an opening sync
    if (!shadow_in_frame) begin
      if (b == sync_shadow) restart_frame();
      return 1'b0;
    end
    // frame already full: any byte overflows
    if (shadow_count >= MAX_FRAME_BYTES) begin
      r.kind             = KIND_OVERFLOW;
      shadow_in_frame    = 1'b0;
      shadow_esc_pending = 1'b0;
      return 1'b1;
    end
    if (shadow_esc_pending) begin
      if (b == sync_shadow) begin
        r.kind = KIND_ESC_ABORT;
        restart_frame();
        return 1'b1;
      end
      b                  = b ^ ESC_XOR;
      shadow_esc_pending = 1'b0;
    end else if (b == escape_shadow) begin
      shadow_esc_pending = 1'b1;
      return 1'b0;
    end else if (b == sync_shadow) begin
      // closing sync
      if (shadow_count == 0) return 1'b0;
      if (shadow_count < MIN_FRAME_BYTES) begin
        r.kind = KIND_SHORT;
        restart_frame();
        return 1'b1;
      end
      got         = {shadow_held[1], shadow_held[0]};
      r.frame_crc = shadow_crc;
      if (got == shadow_crc) begin
        r.kind             = KIND_GOOD;
        shadow_in_frame    = 1'b0;
        shadow_esc_pending = 1'b0;
        shadow_count       = 0;
        shadow_crc         = CRC_INIT;
      end else begin
        r.kind = KIND_CRC_ERR;
        restart_frame();
      end
      return 1'b1;
    end
    // data byte: crc runs two bytes behind
    if (shadow_count >= 2) shadow_crc = crc16_fold(shadow_crc, shadow_held[0]);
    shadow_held[0] = shadow_held[1];
    shadow_held[1] = b;
    r.data_byte    = b;
    shadow_count   = shadow_count + 1;
    return 1'b1;
  endfunction

  // offer one word, with a random gap ahead of it
  task automatic send_word(input logic [BYTE_W-1:0] b);
    deframe_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    words_accepted++;
    if (deframe_predict(b, r)) due_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic send_stuffed(input logic [BYTE_W-1:0] b);
    if (b == sync_shadow || b == escape_shadow) begin
      send_word(escape_shadow);
      send_word(b ^ ESC_XOR);
    end else begin
      send_word(b);
    end
  endtask

  // payload plus little-endian crc, stuffed, then a closing sync
  task automatic send_frame(input byte_q_t payload, input bit corrupt);
    logic [CRC_W-1:0] c;
    c = CRC_INIT;
    foreach (payload[i]) c = crc16_fold(c, payload[i]);
    if (corrupt) c = c ^ (CRC_W'(1) << $urandom_range(CRC_W-1));
    foreach (payload[i]) send_stuffed(payload[i]);
    send_stuffed(c[7:0]);
    send_stuffed(c[15:8]);
    send_word(sync_shadow);
  endtask

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] v;
    do v = BYTE_W'($urandom_range(255)); while (v == sync_shadow || v == escape_shadow);
    return v;
  endfunction

  // random byte with the framing values well represented
  function automatic logic [BYTE_W-1:0] payload_byte();
    int pick;
    pick = $urandom_range(5);
    if (pick == 0) return sync_shadow;
    if (pick == 1) return escape_shadow;
    return BYTE_W'($urandom_range(255));
  endfunction

  // let every due result drain, then cover words still in flight
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SYNC;
    cfg_wdata <= s;
    @(posedge clk);
    sync_shadow = s;
    @(negedge clk);
    cfg_idx   <= CFG_ESCAPE;
    cfg_wdata <= e;
    @(posedge clk);
    escape_shadow = e;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed frames, some broken ones and line noise
  task automatic random_traffic(input int n_words);
    int      start;
    int      choice;
    int      len;
    byte_q_t p;
    start = words_accepted;
    while (words_accepted - start < n_words) begin
      choice = $urandom_range(99);
      p      = {};
      if (choice < 70) begin
        len = $urandom_range(99);
        if (len < 90) len = $urandom_range(8);
        else if (len < 98) len = $urandom_range(40, 9);
        else len = $urandom_range(MAX_FRAME_BYTES - 2, 100);
        repeat (len) p.push_back(payload_byte());
        send_word(sync_shadow);
        send_frame(p, $urandom_range(4) == 0);
      end else if (choice < 80) begin
        send_word(sync_shadow);
        repeat ($urandom_range(3, 1)) send_word(payload_byte());
        send_word(sync_shadow);
      end else if (choice < 88) begin
        send_word(sync_shadow);
        repeat ($urandom_range(6)) send_word(payload_byte());
        send_word(escape_shadow);
        send_word(sync_shadow);
      end else if (choice < 89) begin
        send_word(sync_shadow);
        repeat (MAX_FRAME_BYTES + 1) send_word(plain_byte());
      end else begin
        repeat ($urandom_range(6, 1)) send_word(BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_directed();
    byte_q_t p;
    // hunting noise at both extremes
    send_word(8'h00);
    send_word(8'hff);
    // open, then an empty frame
    send_word(sync_shadow);
    send_word(sync_shadow);
    // too short
    send_word(8'h01);
    send_word(sync_shadow);
    // escape then sync
    send_word(8'h42);
    send_word(escape_shadow);
    send_word(sync_shadow);
    // minimal good frame, back to hunting after it
    p = '{8'h00, 8'hff};
    send_frame(p, 1'b0);
    // frame with stuffed bytes and a bad crc
    send_word(sync_shadow);
    p = '{SYNC_RESET, ESCAPE_RESET};
    send_frame(p, 1'b1);
    quiesce();
  endtask

  task automatic test_overflow();
    byte_q_t p;
    // longest frame that still closes: one byte short of the limit
    repeat (MAX_FRAME_BYTES - 3) p.push_back(plain_byte());
    send_word(sync_shadow);
    send_frame(p, 1'b0);
    // one byte past the limit, a sync at that
    send_word(sync_shadow);
    repeat (MAX_FRAME_BYTES) send_word(plain_byte());
    send_word(sync_shadow);
    // hunting again: this opens a fresh frame
    send_word(sync_shadow);
    quiesce();
  endtask

  task automatic test_sync_equals_escape();
    set_config(8'h55, 8'h55);
    send_word(8'h55);
    send_word(8'h01);
    send_word(8'h02);
    send_word(8'h03);
    send_word(8'h04);
    // escapes, never closes
    send_word(8'h55);
    send_word(8'h10);
    // doubled value aborts
    send_word(8'h55);
    send_word(8'h55);
    random_traffic(40);
    quiesce();
  endtask

  // long result hold-off while the sender keeps offering words
  task automatic test_backpressure();
    byte_q_t p;
    set_config(SYNC_RESET, ESCAPE_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (40) p.push_back(payload_byte());
    @(posedge clk);
    hold_cycles = 200;
    @(negedge clk);
    send_word(sync_shadow);
    send_frame(p, 1'b0);
    quiesce();
  endtask

  task automatic test_idle_phase(input int send_pct, input int recv_pct,
                                 input logic [BYTE_W-1:0] s,
                                 input logic [BYTE_W-1:0] e, input int n_words);
    set_config(s, e);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    random_traffic(n_words);
    quiesce();
  endtask

  // result side: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each result word with the oldest due result
  always @(posedge clk) begin : result_check
    deframe_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result word: kind %0d position %0d", out_ch.kind,
               out_ch.position);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d actual %0d", want.kind, out_ch.kind);
          fail_count++;
        end
        if (out_ch.data_byte !== want.data_byte) begin
          $error("data_byte: expected %0h actual %0h", want.data_byte, out_ch.data_byte);
          fail_count++;
        end
        if (out_ch.position !== want.position) begin
          $error("position: expected %0d actual %0d", want.position, out_ch.position);
          fail_count++;
        end
        if (out_ch.frame_crc !== want.frame_crc) begin
          $error("frame_crc: expected %0h actual %0h", want.frame_crc,
                 out_ch.frame_crc);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_SYNC;
    cfg_wdata     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_overflow();
    test_idle_phase(0, 0, SYNC_RESET, ESCAPE_RESET, 60);
    test_idle_phase(79, 0, 8'h00, 8'hff, 55);
    test_idle_phase(0, 79, 8'hff, 8'h00, 55);
    test_idle_phase(9, 9, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), 55);
    test_sync_equals_escape();
    test_backpressure();

    recv_stall_pct = 0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
